// ===== design/sica_pkg.sv =====
// Package for the signed integer calculator ALU.
// Holds field widths, operation and status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package sica_pkg;

   parameter int MODE_W   = 3;
   parameter int FIELD_W  = 32;
   parameter int STATUS_W = 2;

   parameter logic [MODE_W-1:0] MODE_ADD  = 3'd0;
   parameter logic [MODE_W-1:0] MODE_SUB  = 3'd1;
   parameter logic [MODE_W-1:0] MODE_MUL  = 3'd2;
   parameter logic [MODE_W-1:0] MODE_DIV  = 3'd3;
   parameter logic [MODE_W-1:0] MODE_REM  = 3'd4;
   parameter logic [MODE_W-1:0] MODE_SQRT = 3'd5;
   parameter logic [MODE_W-1:0] MODE_POW  = 3'd6;

   parameter logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   parameter logic [STATUS_W-1:0] STATUS_OVF  = 2'd1;
   parameter logic [STATUS_W-1:0] STATUS_DIV0 = 2'd2;
   parameter logic [STATUS_W-1:0] STATUS_NSQ  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_MCHK,
      ST_DIV,
      ST_DFIX,
      ST_SQRT,
      ST_FIN
   } state_type;

endpackage

// ===== design/sica_if.sv =====
// Valid/ready channel interfaces for the signed integer calculator ALU.
// Request carries mode and operands, response carries result and status.
// Depends on sica_pkg.
`timescale 1ns / 1ps

interface sica_req_if;
   import sica_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [FIELD_W-1:0] operand_a;
   logic signed [FIELD_W-1:0] operand_b;

   modport source (output valid, output mode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input mode, input operand_a, input operand_b,
                   output ready);
endinterface

interface sica_rsp_if;
   import sica_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] result;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output result, output status, input ready);
   modport sink   (input valid, input result, input status, output ready);
endinterface

// ===== design/signed_integer_calculator_alu_unit.sv =====
// Add, sub, trivial power, divide by zero and negative root go from load straight to finish;
// mul takes one multiply and overflow check; div/rem take DATA_WIDTH restoring steps (one
// per quotient bit) and a sign fix; sqrt takes (DATA_WIDTH+1)/2 steps (one per root bit);
// power takes k <= DATA_WIDTH products through the shared multiplier. Results wait in the
// output register while the next request is taken; finish stalls until that register is free.
// Reset is synchronous: clears the sequencer and the response valid.
`timescale 1ns / 1ps

module signed_integer_calculator_alu_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   sica_req_if.sink   req_if,
   sica_rsp_if.source rsp_if
);
   import sica_pkg::*;

   localparam int DW       = DATA_WIDTH;
   localparam int UW       = DATA_WIDTH + 1;
   localparam int SQ_STEPS = (DATA_WIDTH + 1) / 2;
   localparam int SQ_TOP   = 2 * (SQ_STEPS - 1);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]     op_ff, op_in;
   logic signed [DW-1:0]  a_ff, a_in;
   logic signed [DW-1:0]  b_ff, b_in;
   logic signed [DW-1:0]  acc_ff, acc_in;
   logic [UW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         bit_ff, bit_in;
   logic [DW-1:0]         dvs_ff, dvs_in;
   logic [DW-1:0]         cnt_ff, cnt_in;
   logic signed [2*DW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0]  res_ff, res_in;
   logic [STATUS_W-1:0]   sts_ff, sts_in;
   logic signed [DW-1:0]  rsp_res_ff, rsp_res_in;
   logic [STATUS_W-1:0]   rsp_sts_ff, rsp_sts_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic            req_fire;
   logic            rsp_free;
   logic            a_neg, b_neg, b_zero, a_trivial;
   logic            mul_ovf, last;
   logic [DW-1:0]   a_mag, b_mag;
   logic [UW-1:0]   sub_x, sub_y;
   logic [UW:0]     sub_diff;
   logic            sub_ge;
   logic [DW:0]     addsub;

   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign a_neg     = a_ff[DW-1];
   assign b_neg     = b_ff[DW-1];
   assign b_zero    = (b_ff == '0);
   assign a_trivial = (a_ff == '0) || (a_ff == DW'(1)) || (&a_ff);
   assign a_mag     = a_neg ? DW'(~a_ff + 1'b1) : DW'(a_ff);
   assign b_mag     = b_neg ? DW'(~b_ff + 1'b1) : DW'(b_ff);
   assign last      = (cnt_ff == DW'(1));
   assign mul_ovf   = !((&prod_ff[2*DW-1:DW-1]) || !(|prod_ff[2*DW-1:DW-1]));
   assign addsub    = (op_ff == MODE_SUB) ? ({a_ff[DW-1], a_ff} - {b_ff[DW-1], b_ff})
                                          : ({a_ff[DW-1], a_ff} + {b_ff[DW-1], b_ff});

   // shared subtractor: restoring divide step or square root step
   assign sub_x    = (state_ff == ST_DIV) ? {rem_ff[DW-1:0], acc_ff[DW-1]} : rem_ff;
   assign sub_y    = (state_ff == ST_DIV) ? {1'b0, dvs_ff} : {1'b0, (acc_ff | bit_ff)};
   assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
   assign sub_ge   = !sub_diff[UW];

   assign prod_in  = acc_ff * a_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            case (op_ff)
               MODE_MUL:           state_in = ST_MUL;
               MODE_DIV, MODE_REM: state_in = b_zero ? ST_FIN : ST_DIV;
               MODE_SQRT:          state_in = a_neg ? ST_FIN : ST_SQRT;
               MODE_POW:           state_in = (b_neg || b_zero || a_trivial) ? ST_FIN : ST_MUL;
               default:            state_in = ST_FIN;
            endcase
         end
         ST_MUL:  state_in = ST_MCHK;
         ST_MCHK: state_in = (mul_ovf || last) ? ST_FIN : ST_MUL;
         ST_DIV:  state_in = last ? ST_DFIX : ST_DIV;
         ST_DFIX: state_in = ST_FIN;
         ST_SQRT: state_in = last ? ST_FIN : ST_SQRT;
         ST_FIN: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [DW-1:0] root;
      op_in  = op_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      sts_in = sts_ff;
      root   = acc_ff >> 1;
      case (state_ff)
         ST_IDLE: begin
            op_in = req_if.mode;
            a_in  = req_if.operand_a[DW-1:0];
            b_in  = req_if.operand_b[DW-1:0];
         end
         ST_LOAD: begin
            res_in = '0;
            sts_in = STATUS_OK;
            case (op_ff)
               MODE_ADD, MODE_SUB: begin
                  if (addsub[DW] != addsub[DW-1]) sts_in = STATUS_OVF;
                  else res_in = addsub[DW-1:0];
               end
               MODE_MUL: begin
                  acc_in = b_ff;
                  cnt_in = DW'(1);
               end
               MODE_DIV, MODE_REM: begin
                  if (b_zero) sts_in = STATUS_DIV0;
                  acc_in = a_mag;
                  dvs_in = b_mag;
                  rem_in = '0;
                  cnt_in = DW'(DATA_WIDTH);
               end
               MODE_SQRT: begin
                  if (a_neg) sts_in = STATUS_NSQ;
                  rem_in = {1'b0, a_ff};
                  acc_in = '0;
                  bit_in = DW'(1) << SQ_TOP;
                  cnt_in = DW'(SQ_STEPS);
               end
               MODE_POW: begin
                  if (b_neg) res_in = '0;
                  else if (b_zero) res_in = DW'(1);
                  else if (&a_ff) res_in = b_ff[0] ? '1 : DW'(1);
                  else if (a_trivial) res_in = a_ff;
                  acc_in = DW'(1);
                  cnt_in = b_ff;
               end
               default: res_in = '0;
            endcase
         end
         ST_MCHK: begin
            if (mul_ovf) begin
               sts_in = STATUS_OVF;
               res_in = '0;
            end else begin
               acc_in = prod_ff[DW-1:0];
               cnt_in = cnt_ff - 1'b1;
               res_in = prod_ff[DW-1:0];
            end
         end
         ST_DIV: begin
            rem_in = sub_ge ? sub_diff[UW-1:0] : sub_x;
            acc_in = {acc_ff[DW-2:0], sub_ge};
            cnt_in = cnt_ff - 1'b1;
         end
         ST_DFIX: begin
            if (op_ff == MODE_DIV) begin
               if (a_neg ^ b_neg) res_in = DW'(~acc_ff + 1'b1);
               else if (acc_ff[DW-1]) sts_in = STATUS_OVF;
               else res_in = acc_ff;
            end else begin
               res_in = a_neg ? DW'(~rem_ff[DW-1:0] + 1'b1) : rem_ff[DW-1:0];
            end
         end
         ST_SQRT: begin
            if (sub_ge) begin
               rem_in = sub_diff[UW-1:0];
               root   = (acc_ff >> 1) | bit_ff;
            end
            acc_in = root;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            res_in = root;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_res_in   = rsp_res_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_res_in   = res_ff;
         rsp_sts_in   = sts_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      sts_ff     <= sts_in;
      rsp_res_ff <= rsp_res_in;
      rsp_sts_ff <= rsp_sts_in;
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.result = FIELD_W'(rsp_res_ff);
   assign rsp_if.status = rsp_sts_ff;

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOAD)
      else $error("accepted transaction did not enter load");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_SQRT || state_ff == ST_MCHK) |-> cnt_ff != '0)
      else $error("iteration count ran out");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sts_ff != STATUS_OK) |-> rsp_res_ff == '0)
      else $error("nonzero result with error status");

   a_nsq_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && sts_ff == STATUS_NSQ) |-> op_ff == MODE_SQRT)
      else $error("negative root status outside sqrt");

   a_div0_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && sts_ff == STATUS_DIV0) |-> (op_ff == MODE_DIV || op_ff == MODE_REM))
      else $error("divide by zero status outside div/rem");

endmodule
